// ===== rtl/wbm_pkg.sv =====
package wbm_pkg;

	// Fixed geometry of the stores
	localparam int unsigned MAX_REFS     = 64;
	localparam int unsigned FEATURE_BITS = 1024;
	localparam int unsigned WORD_BITS    = 32;
	localparam int unsigned NWORDS       = FEATURE_BITS / WORD_BITS;
	localparam int unsigned REF_W        = $clog2(MAX_REFS);
	localparam int unsigned WIDX_W       = $clog2(NWORDS);
	localparam int unsigned BIT_W        = $clog2(WORD_BITS);
	localparam int unsigned DIM_W        = $clog2(FEATURE_BITS);
	localparam int unsigned SCORE_W      = 26;
	localparam int unsigned WEIGHT_W     = 16;
	localparam int unsigned ACC_W        = 4;
	localparam int unsigned CNT_W        = 7;

	// Width of the spread times fraction product that the divider takes
	localparam int unsigned DIV_W        = SCORE_W + ACC_W;

	// Command codes
	localparam logic [1:0] CMD_LOAD_REF    = 2'd0;
	localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd1;
	localparam logic [1:0] CMD_QUERY       = 2'd2;

	// Register indexes
	localparam logic CFG_REF_COUNT     = 1'b0;
	localparam logic CFG_ACCEPT_TENTHS = 1'b1;

	// Divider handshake
	typedef struct packed {
		logic                 go;
		logic [DIV_W-1:0]     dividend;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_W-1:0]     quotient;
	} div_rsp_t;

endpackage

// ===== rtl/wbm_div10.sv =====
// Division by ten through multiplication with the rounded-up reciprocal 2^35/10,
// which is exact for every operand below 2^34. The operand is registered first and
// the product after it; done rises together with the registered product.
module wbm_div10 (
	input  logic               clk,
	input  logic               arst_n,
	input  wbm_pkg::div_req_t  req,
	output wbm_pkg::div_rsp_t  rsp
);

	localparam int unsigned PROD_W      = wbm_pkg::DIV_W + 32;
	localparam logic [31:0] RECIP_TENTH = 32'hCCCC_CCCD;
	localparam int unsigned RECIP_SHIFT = 35;

	logic                       run_q;
	logic [wbm_pkg::DIV_W-1:0]  x_q;
	logic [PROD_W-1:0]          prod_q;
	logic                       done_q;

	// Two-step control: operand registered, then product registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			run_q  <= req.go;
			done_q <= run_q;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (req.go) begin
			x_q <= req.dividend;
		end
		if (run_q) begin
			prod_q <= PROD_W'(x_q) * PROD_W'(RECIP_TENTH);
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = wbm_pkg::DIV_W'(prod_q >> RECIP_SHIFT);

	property p_no_restart;
		@(posedge clk) disable iff (!arst_n) run_q |-> !req.go;
	endproperty
	a_no_restart: assert property (p_no_restart) else $error("divider restarted while running");

	property p_done_pulse;
		@(posedge clk) disable iff (!arst_n) done_q |=> !done_q;
	endproperty
	a_done_pulse: assert property (p_done_pulse) else $error("divider done held");

	property p_done_after_run;
		@(posedge clk) disable iff (!arst_n) done_q |-> !run_q;
	endproperty
	a_done_after_run: assert property (p_done_after_run) else $error("done while running");

endmodule

// ===== rtl/weighted_bit_match_candidate_select.sv =====
// Weighted bit-match candidate selection. Loads (cmd 0 reference word, cmd 1 weight)
// and query words without the last mark are accepted directly: busy stays low and the
// next command may follow at once. A query word marked last starts the scoring pass,
// during which busy is high. The pass visits each active reference word by word:
// a read, an AND of query and reference word, then one weight memory read per shared
// set bit, and a closing step per reference; then the threshold (a reciprocal
// multiplication by one tenth), then a read and a check per reference to select
// candidates, and a final flush step. Results appear in ascending reference order,
// one per cycle at most, each shown on the result ports for one cycle with
// result_strobe high; the receiver cannot hold them off. Configuration may only be
// written while busy is low and no result is pending.
module weighted_bit_match_candidate_select (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     cmd,
	input  logic [5:0]                     ref_id,
	input  logic [4:0]                     word_index,
	input  logic [31:0]                    bit_word,
	input  logic [9:0]                     dim,
	input  logic [15:0]                    weight_value,
	input  logic                           query_last,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [6:0]                     cfg_data,
	output logic                           result_strobe,
	output logic [5:0]                     candidate_id,
	output logic [25:0]                    candidate_score,
	output logic                           candidate_valid,
	output logic                           run_last
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RD    = 4'd1;
	localparam logic [3:0] ST_AND   = 4'd2;
	localparam logic [3:0] ST_BITS  = 4'd3;
	localparam logic [3:0] ST_REND  = 4'd4;
	localparam logic [3:0] ST_MUL   = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_EMRD  = 4'd7;
	localparam logic [3:0] ST_EMCHK = 4'd8;
	localparam logic [3:0] ST_FLUSH = 4'd9;

	localparam int unsigned REF_W   = wbm_pkg::REF_W;
	localparam int unsigned WIDX_W  = wbm_pkg::WIDX_W;
	localparam int unsigned BIT_W   = wbm_pkg::BIT_W;
	localparam int unsigned SCORE_W = wbm_pkg::SCORE_W;
	localparam int unsigned WORD_B  = wbm_pkg::WORD_BITS;
	localparam int unsigned CNT_W   = wbm_pkg::CNT_W;

	// Stores
	logic [WORD_B-1:0]            refmem [wbm_pkg::MAX_REFS*wbm_pkg::NWORDS];
	logic [wbm_pkg::WEIGHT_W-1:0] wmem   [wbm_pkg::FEATURE_BITS];
	logic [WORD_B-1:0]            qmem   [wbm_pkg::NWORDS];
	logic [SCORE_W-1:0]           smem   [wbm_pkg::MAX_REFS];
	logic [wbm_pkg::NWORDS-1:0]   qv_q;
	logic [wbm_pkg::MAX_REFS-1:0] touched_q;

	logic [3:0]                   state_q;
	logic [6:0]                   ref_count_q;
	logic [3:0]                   acc_q;
	logic [CNT_W-1:0]             n_w;
	logic [3:0]                   acc_w;
	logic [CNT_W-1:0]             r_q;
	logic [WIDX_W-1:0]            w_q;
	logic [WORD_B-1:0]            s_q;
	logic                         pend_q;
	logic                         tch_q;
	logic [SCORE_W-1:0]           score_q;
	logic                         any_q;
	logic [SCORE_W-1:0]           mn_q;
	logic [SCORE_W-1:0]           mx_q;
	logic [SCORE_W-1:0]           thr_q;
	logic [WORD_B-1:0]            qd_q;
	logic [WORD_B-1:0]            rd_q;
	logic [wbm_pkg::WEIGHT_W-1:0] wd_q;
	logic [SCORE_W-1:0]           sd_q;
	logic                         have_q;
	logic [REF_W-1:0]             pid_q;
	logic [SCORE_W-1:0]           pscore_q;
	logic                         pvalid_q;
	logic                         out_stb_q;
	logic [REF_W-1:0]             out_id_q;
	logic [SCORE_W-1:0]           out_score_q;
	logic                         out_valid_q;
	logic                         out_last_q;
	logic [BIT_W-1:0]             ff_idx;
	logic                         accept;
	logic                         last_ref;
	wbm_pkg::div_req_t            div_req;
	wbm_pkg::div_rsp_t            div_rsp;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign last_ref = (r_q == n_w - 1'b1);

	// Registers out of range act as their maximum
	always_comb begin
		n_w   = (ref_count_q > CNT_W'(wbm_pkg::MAX_REFS)) ? CNT_W'(wbm_pkg::MAX_REFS)
		                                                   : ref_count_q;
		acc_w = (acc_q > 4'd10) ? 4'd10 : acc_q;
	end

	// Lowest set bit of the remaining shared word
	always_comb begin
		ff_idx = '0;
		for (int i = WORD_B - 1; i >= 0; i--) begin
			if (s_q[i]) begin
				ff_idx = BIT_W'(i);
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_count_q <= 7'd64;
			acc_q       <= 4'd7;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wbm_pkg::CFG_REF_COUNT:     ref_count_q <= cfg_data;
				wbm_pkg::CFG_ACCEPT_TENTHS: acc_q       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Memory writes and registered reads
	always_ff @(posedge clk) begin
		if (accept && cmd == wbm_pkg::CMD_LOAD_REF) begin
			refmem[{ref_id, word_index}] <= bit_word;
		end
		if (accept && cmd == wbm_pkg::CMD_LOAD_WEIGHT) begin
			wmem[dim] <= weight_value;
		end
		if (accept && cmd == wbm_pkg::CMD_QUERY) begin
			qmem[word_index] <= bit_word;
		end
		if (state_q == ST_RD) begin
			qd_q <= qmem[w_q];
			rd_q <= refmem[{r_q[REF_W-1:0], w_q}];
		end
		if (state_q == ST_BITS && s_q != '0) begin
			wd_q <= wmem[{w_q, ff_idx}];
		end
		if (state_q == ST_REND) begin
			smem[r_q[REF_W-1:0]] <= score_q;
		end
		if (state_q == ST_EMRD) begin
			sd_q <= smem[r_q[REF_W-1:0]];
		end
	end

	// Threshold division
	assign div_req.go       = (state_q == ST_MUL) && any_q;
	assign div_req.dividend = wbm_pkg::DIV_W'(mx_q - mn_q) * wbm_pkg::DIV_W'(acc_w);

	wbm_div10 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			qv_q      <= '0;
			touched_q <= '0;
			r_q       <= '0;
			w_q       <= '0;
			pend_q    <= 1'b0;
			tch_q     <= 1'b0;
			any_q     <= 1'b0;
			have_q    <= 1'b0;
			out_stb_q <= 1'b0;
		end else begin
			out_stb_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && cmd == wbm_pkg::CMD_QUERY) begin
						if (query_last) begin
							r_q     <= '0;
							w_q     <= '0;
							score_q <= '0;
							tch_q   <= 1'b0;
							any_q   <= 1'b0;
							if (n_w == '0) begin
								qv_q    <= '0;
								state_q <= ST_MUL;
							end else begin
								qv_q[word_index] <= 1'b1;
								state_q          <= ST_RD;
							end
						end else begin
							qv_q[word_index] <= 1'b1;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_AND;
				end
				ST_AND: begin
					s_q     <= qv_q[w_q] ? (qd_q & rd_q) : '0;
					pend_q  <= 1'b0;
					state_q <= ST_BITS;
				end
				ST_BITS: begin
					if (pend_q) begin
						score_q <= score_q + SCORE_W'(wd_q);
					end
					if (s_q != '0) begin
						s_q    <= s_q & (s_q - 1'b1);
						pend_q <= 1'b1;
						tch_q  <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (w_q == WIDX_W'(wbm_pkg::NWORDS - 1)) begin
							state_q <= ST_REND;
						end else begin
							w_q     <= w_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_REND: begin
					touched_q[r_q[REF_W-1:0]] <= tch_q;
					if (tch_q) begin
						any_q <= 1'b1;
						if (!any_q || score_q < mn_q) mn_q <= score_q;
						if (!any_q || score_q > mx_q) mx_q <= score_q;
					end
					score_q <= '0;
					tch_q   <= 1'b0;
					w_q     <= '0;
					if (last_ref) begin
						qv_q    <= '0;
						state_q <= ST_MUL;
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_MUL: begin
					if (any_q) begin
						state_q <= ST_DIV;
					end else begin
						pid_q    <= '0;
						pscore_q <= '0;
						pvalid_q <= 1'b0;
						state_q  <= ST_FLUSH;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						thr_q   <= mn_q + div_rsp.quotient[SCORE_W-1:0];
						r_q     <= '0;
						have_q  <= 1'b0;
						state_q <= ST_EMRD;
					end
				end
				ST_EMRD: begin
					state_q <= ST_EMCHK;
				end
				ST_EMCHK: begin
					if (touched_q[r_q[REF_W-1:0]] && sd_q >= thr_q) begin
						if (have_q) begin
							out_stb_q   <= 1'b1;
							out_id_q    <= pid_q;
							out_score_q <= pscore_q;
							out_valid_q <= 1'b1;
							out_last_q  <= 1'b0;
						end
						have_q   <= 1'b1;
						pid_q    <= r_q[REF_W-1:0];
						pscore_q <= sd_q;
						pvalid_q <= 1'b1;
					end
					if (last_ref) begin
						state_q <= ST_FLUSH;
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= ST_EMRD;
					end
				end
				ST_FLUSH: begin
					out_stb_q   <= 1'b1;
					out_id_q    <= pid_q;
					out_score_q <= pscore_q;
					out_valid_q <= pvalid_q;
					out_last_q  <= 1'b1;
					have_q      <= 1'b0;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_strobe   = out_stb_q;
	assign candidate_id    = out_id_q;
	assign candidate_score = out_score_q;
	assign candidate_valid = out_valid_q;
	assign run_last        = out_last_q;

	property p_invalid_is_last;
		@(posedge clk) disable iff (!arst_n)
			result_strobe && !candidate_valid |-> run_last;
	endproperty
	a_invalid_is_last: assert property (p_invalid_is_last)
		else $error("invalid result not marked last");

	property p_query_cleared;
		@(posedge clk) disable iff (!arst_n)
			result_strobe && run_last |-> (qv_q == '0);
	endproperty
	a_query_cleared: assert property (p_query_cleared)
		else $error("query words not cleared after scoring");

	property p_last_then_idle;
		@(posedge clk) disable iff (!arst_n)
			result_strobe && run_last |-> !busy;
	endproperty
	a_last_then_idle: assert property (p_last_then_idle)
		else $error("busy after final result");

	property p_div_only_in_div;
		@(posedge clk) disable iff (!arst_n)
			div_rsp.done |-> (state_q == ST_DIV);
	endproperty
	a_div_only_in_div: assert property (p_div_only_in_div)
		else $error("divider finished outside threshold step");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

	// Command code that the block does not know and must ignore
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 4000000;
	localparam int unsigned RANDOM_ITEMS = 60;
	// Stimulus footprint: only these references are ever active, and queries that are scored
	// only carry the lowest and the highest word, so only those stores need filling.
	localparam int unsigned ACTIVE_REFS = 3;
	localparam logic [4:0]  LOW_WORD = 5'd0;
	localparam logic [4:0]  HIGH_WORD = 5'd31;

	typedef struct {
		logic [1:0]  cmd;
		logic [5:0]  rid;
		logic [4:0]  wi;
		logic [31:0] bits;
		logic [9:0]  dim;
		logic [15:0] wv;
		logic        last;
	} command_t;

	typedef struct {
		logic [5:0]  id;
		logic [25:0] score;
		logic        valid;
		logic        last;
	} candidate_t;

	// One row of the directed part, with an optional typed-in expected result
	typedef struct {
		logic [1:0]  cmd;
		logic [5:0]  rid;
		logic [4:0]  wi;
		logic [31:0] bits;
		logic [9:0]  dim;
		logic [15:0] wv;
		logic        last;
		bit          typed;
		logic [5:0]  e_id;
		logic [25:0] e_score;
		logic        e_valid;
		logic        e_last;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [5:0]  ref_id;
	logic [4:0]  word_index;
	logic [31:0] bit_word;
	logic [9:0]  dim;
	logic [15:0] weight_value;
	logic        query_last;
	logic        cfg_we;
	logic        cfg_index;
	logic [6:0]  cfg_data;
	logic        result_strobe;
	logic [5:0]  candidate_id;
	logic [25:0] candidate_score;
	logic        candidate_valid;
	logic        run_last;

	weighted_bit_match_candidate_select dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .ref_id(ref_id), .word_index(word_index), .bit_word(bit_word),
		.dim(dim), .weight_value(weight_value), .query_last(query_last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_strobe(result_strobe), .candidate_id(candidate_id),
		.candidate_score(candidate_score), .candidate_valid(candidate_valid),
		.run_last(run_last)
	);

	// Shadow copy of the block's stores and registers
	logic [31:0] shadow_refs [wbm_pkg::MAX_REFS][wbm_pkg::NWORDS];
	logic [15:0] shadow_weights [wbm_pkg::FEATURE_BITS];
	logic [31:0] shadow_query [wbm_pkg::NWORDS];
	logic [6:0]  shadow_ref_count;
	logic [3:0]  shadow_tenths;

	candidate_t  pending_candidates[$];
	int          errors;
	int          idle_pct;
	longint      cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Score the held query against every active reference and select candidates.
	function automatic void score_candidates(ref candidate_t picks[$]);
		logic [25:0] scores [wbm_pkg::MAX_REFS];
		bit          hit [wbm_pkg::MAX_REFS];
		int unsigned nrefs, frac;
		logic [31:0] shared;
		logic [25:0] lo, hi, thr;
		bit          any;
		candidate_t  c;
		nrefs = (shadow_ref_count > wbm_pkg::MAX_REFS) ? wbm_pkg::MAX_REFS : shadow_ref_count;
		frac = (shadow_tenths > 10) ? 10 : shadow_tenths;
		any = 0;
		lo = 0;
		hi = 0;
		for (int r = 0; r < nrefs; r++) begin
			scores[r] = 0;
			hit[r] = 0;
			for (int w = 0; w < wbm_pkg::NWORDS; w++) begin
				shared = shadow_query[w] & shadow_refs[r][w];
				for (int b = 0; b < wbm_pkg::WORD_BITS; b++) begin
					if (shared[b]) begin
						hit[r] = 1;
						scores[r] += shadow_weights[w * wbm_pkg::WORD_BITS + b];
					end
				end
			end
			if (hit[r]) begin
				if (!any || scores[r] < lo) lo = scores[r];
				if (!any || scores[r] > hi) hi = scores[r];
				any = 1;
			end
		end
		for (int w = 0; w < wbm_pkg::NWORDS; w++) shadow_query[w] = '0;
		if (!any) begin
			c = '{id: 0, score: 0, valid: 1'b0, last: 1'b1};
			picks = {picks, c};
			return;
		end
		thr = lo + 26'((64'(hi - lo) * frac) / 10);
		for (int r = 0; r < nrefs; r++) begin
			if (hit[r] && scores[r] >= thr) begin
				c = '{id: 6'(r), score: scores[r], valid: 1'b1, last: 1'b0};
				picks = {picks, c};
			end
		end
		picks[picks.size() - 1].last = 1'b1;
	endfunction

	// Apply one accepted transaction to the shadow state.
	function automatic void apply_command(input command_t c, ref candidate_t picks[$]);
		case (c.cmd)
			wbm_pkg::CMD_LOAD_REF: begin
				shadow_refs[c.rid][c.wi] = c.bits;
			end
			wbm_pkg::CMD_LOAD_WEIGHT: begin
				shadow_weights[c.dim] = c.wv;
			end
			wbm_pkg::CMD_QUERY: begin
				shadow_query[c.wi] = c.bits;
				if (c.last) score_candidates(picks);
			end
			default: begin
			end
		endcase
	endfunction

	// Drive one transaction, wait for acceptance, and queue its expectations.
	task automatic issue(input command_t c, input bit typed, input candidate_t want);
		candidate_t picks[$];
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		cmd = c.cmd;
		ref_id = c.rid;
		word_index = c.wi;
		bit_word = c.bits;
		dim = c.dim;
		weight_value = c.wv;
		query_last = c.last;
		do @(posedge clk); while (busy);
		apply_command(c, picks);
		if (typed) pending_candidates = {pending_candidates, want};
		else pending_candidates = {pending_candidates, picks};
	endtask

	// Write a register once the block has drained.
	task automatic write_register(input logic idx, input logic [6:0] value);
		@(negedge clk);
		start = 1'b0;
		while (pending_candidates.size() != 0 || busy) @(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == wbm_pkg::CFG_REF_COUNT) shadow_ref_count = value;
		else shadow_tenths = value[3:0];
	endtask

	task automatic plain(input command_t c);
		candidate_t none;
		none = '{id: 0, score: 0, valid: 0, last: 0};
		issue(c, 1'b0, none);
	endtask

	function automatic logic [31:0] sparse_word();
		case ($urandom_range(3))
			0: return $urandom() & $urandom() & $urandom();
			1: return $urandom() & $urandom();
			2: return 32'(1) << $urandom_range(31);
			default: return $urandom();
		endcase
	endfunction

	// Queries only carry the two words whose weights are loaded.
	function automatic logic [4:0] query_word();
		return ($urandom_range(1) == 0) ? LOW_WORD : HIGH_WORD;
	endfunction

	// Compare every result transaction with the oldest expectation.
	always @(posedge clk) begin
		candidate_t e;
		if (result_strobe) begin
			if (pending_candidates.size() == 0) begin
				$display("%0t: unexpected result id=%0d score=%0d valid=%0b last=%0b",
					$time, candidate_id, candidate_score, candidate_valid, run_last);
				errors++;
			end else begin
				e = pending_candidates.pop_front();
				if (candidate_id !== e.id) begin
					$display("%0t: candidate_id expected %0d got %0d", $time, e.id, candidate_id);
					errors++;
				end
				if (candidate_score !== e.score) begin
					$display("%0t: candidate_score expected %0d got %0d",
						$time, e.score, candidate_score);
					errors++;
				end
				if (candidate_valid !== e.valid) begin
					$display("%0t: candidate_valid expected %0b got %0b",
						$time, e.valid, candidate_valid);
					errors++;
				end
				if (run_last !== e.last) begin
					$display("%0t: run_last expected %0b got %0b", $time, e.last, run_last);
					errors++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		stim_row_t   rows[$];
		command_t    c;
		candidate_t  want;
		int          sent, words;
		logic [6:0]  counts [6];
		logic [6:0]  tenths [6];
		int          idles [6];

		errors = 0;
		cycles = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = wbm_pkg::CMD_LOAD_REF;
		ref_id = '0;
		word_index = '0;
		bit_word = '0;
		dim = '0;
		weight_value = '0;
		query_last = 1'b0;
		cfg_we = 1'b0;
		cfg_index = wbm_pkg::CFG_REF_COUNT;
		cfg_data = '0;
		shadow_ref_count = 7'd64;
		shadow_tenths = 4'd7;
		for (int w = 0; w < wbm_pkg::NWORDS; w++) shadow_query[w] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill every word of the active references and the weights of both query
		// words, so that no scoring pass reads an unwritten entry.
		write_register(wbm_pkg::CFG_REF_COUNT, 7'(ACTIVE_REFS));
		for (int r = 0; r < ACTIVE_REFS; r++)
			for (int w = 0; w < wbm_pkg::NWORDS; w++)
				plain('{wbm_pkg::CMD_LOAD_REF, 6'(r), 5'(w), $urandom() & $urandom(), 0, 0, 0});
		for (int b = 0; b < wbm_pkg::WORD_BITS; b++) begin
			plain('{wbm_pkg::CMD_LOAD_WEIGHT, 0, 0, 0, 10'(b),
				($urandom_range(7) == 0) ? 16'h0 : 16'($urandom()), 0});
			plain('{wbm_pkg::CMD_LOAD_WEIGHT, 0, 0, 0,
				10'(wbm_pkg::FEATURE_BITS - wbm_pkg::WORD_BITS + b),
				($urandom_range(7) == 0) ? 16'h0 : 16'($urandom()), 0});
		end

		// Directed part: empty query, unknown command, extremes, zero-weight shares.
		rows.push_front('{wbm_pkg::CMD_QUERY, 0, 5'd0, 32'h0, 0, 0, 1, 1, 0, 0, 0, 1});
		rows.insert(0, '{wbm_pkg::CMD_QUERY, 0, 5'd31, '1, 0, 0, 1, 0, 0, 0, 0, 0});
		rows.insert(0, '{wbm_pkg::CMD_QUERY, 0, 5'd0, '1, 0, 0, 0, 0, 0, 0, 0, 0});
		rows.insert(0, '{wbm_pkg::CMD_LOAD_REF, 6'd1, 5'd0, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0});
		rows.insert(0, '{wbm_pkg::CMD_QUERY, 0, 5'd0, 32'h1, 0, 0, 1, 0, 0, 0, 0, 0});
		rows.insert(0, '{wbm_pkg::CMD_LOAD_REF, 6'd0, 5'd0, 32'h1, 0, 0, 0, 0, 0, 0, 0, 0});
		rows.insert(0, '{wbm_pkg::CMD_LOAD_WEIGHT, 0, 0, 0, 10'd0, 16'h0, 0, 0, 0, 0, 0, 0});
		rows.insert(0, '{wbm_pkg::CMD_QUERY, 0, 5'd31, 32'h8000_0000, 0, 0, 1,
			0, 0, 0, 0, 0});
		rows.insert(0, '{wbm_pkg::CMD_LOAD_WEIGHT, 0, 0, 0, 10'd1023, 16'hFFFF, 0,
			0, 0, 0, 0, 0});
		rows.insert(0, '{wbm_pkg::CMD_LOAD_REF, 6'd63, 5'd31, '1, 0, 0, 0, 0, 0, 0, 0, 0});
		rows.insert(0, '{CMD_UNKNOWN, 6'd63, 5'd31, '1, '1, '1, 1, 0, 0, 0, 0, 0});
		rows.insert(0, '{wbm_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 1});
		foreach (rows[i]) begin
			c = '{rows[i].cmd, rows[i].rid, rows[i].wi, rows[i].bits, rows[i].dim,
				rows[i].wv, rows[i].last};
			want = '{rows[i].e_id, rows[i].e_score, rows[i].e_valid, rows[i].e_last};
			issue(c, rows[i].typed, want);
		end

		// No reference active: the query gives the invalid result.
		write_register(wbm_pkg::CFG_REF_COUNT, 7'd0);
		want = '{id: 0, score: 0, valid: 0, last: 1};
		issue('{wbm_pkg::CMD_QUERY, 0, 5'd3, '1, 0, 0, 1}, 1'b1, want);

		// Random phases with varied register settings and sender idling.
		counts = '{7'd3, 7'd1, 7'd2, 7'd3, 7'd2, 7'd3};
		tenths = '{7'd0, 7'd10, 7'd15, 7'd3, 7'd127, 7'd5};
		idles  = '{0, 83, 0, 20, 83, 0};
		sent = 0;
		for (int p = 0; p < 6; p++) begin
			write_register(wbm_pkg::CFG_REF_COUNT, counts[p]);
			write_register(wbm_pkg::CFG_ACCEPT_TENTHS, tenths[p]);
			idle_pct = idles[p];
			while (sent < (p + 1) * RANDOM_ITEMS / 6) begin
				case ($urandom_range(9))
					0, 1: begin
						plain('{wbm_pkg::CMD_LOAD_REF, 6'($urandom()), 5'($urandom()),
							sparse_word(), 0, 0, 0});
						sent++;
					end
					2: begin
						plain('{wbm_pkg::CMD_LOAD_WEIGHT, 0, 0, 0, 10'($urandom()),
							16'($urandom()), 0});
						sent++;
					end
					3: begin
						plain('{CMD_UNKNOWN, 6'($urandom()), 5'($urandom()), $urandom(),
							10'($urandom()), 16'($urandom()), 1'($urandom())});
					end
					default: begin
						words = $urandom_range(1, 3);
						for (int k = 0; k < words; k++) begin
							plain('{wbm_pkg::CMD_QUERY, 6'($urandom()), query_word(),
								sparse_word(), 10'($urandom()), 16'($urandom()),
								1'(k == words - 1)});
							sent++;
						end
					end
				endcase
			end
		end

		@(negedge clk);
		start = 1'b0;
		while (pending_candidates.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
